// File: rtl/core/tlc_pkg.sv
// Shared types and constants of the two-level cache tracker.
package tlc_pkg;

	localparam int L1_SETS_LOG2 = 8;
	localparam int L1_WAYS_MAX  = 4;
	localparam int L2_SETS_LOG2 = 10;
	localparam int L2_WAYS_MAX  = 8;

	localparam int L1_WAY_W = $clog2(L1_WAYS_MAX) > 0 ? $clog2(L1_WAYS_MAX) : 1;
	localparam int L2_WAY_W = $clog2(L2_WAYS_MAX) > 0 ? $clog2(L2_WAYS_MAX) : 1;

	typedef enum logic [2:0] {
		ST_NONE  = 3'd0,
		ST_RHIT  = 3'd1,
		ST_RMISS = 3'd2,
		ST_WHIT  = 3'd3,
		ST_WMISS = 3'd4
	} status_t;

	localparam logic [2:0] REG_L1_OFF  = 3'd0;
	localparam logic [2:0] REG_L1_SETS = 3'd1;
	localparam logic [2:0] REG_L1_WAYS = 3'd2;
	localparam logic [2:0] REG_L2_OFF  = 3'd3;
	localparam logic [2:0] REG_L2_SETS = 3'd4;
	localparam logic [2:0] REG_L2_WAYS = 3'd5;

	// Per-level outcome handed from a level to the top level.
	typedef struct packed {
		logic hit;
		logic done;
	} lvl_res_t;

endpackage

// File: rtl/core/two_level_cache_hit_miss_tracker_unit.sv
// Top level of the two-level cache tracker: handshakes, registers, sequencing.
// An accepted input looks up L1, then L2 only on an L1 miss, before its result is
// registered. A new access is accepted only once the previous one has finished;
// each level reads one set row from its memory and, on a read miss, writes back a
// tag with its valid bit or the replacement pointer. An access waits in its last
// step while the previous result is still held by the receiver. Reset: registers
// take 3, 8, 4, 4, 10, 8; a clearing pass then clears valid bits and pointers, during which no access is accepted.
module two_level_cache_hit_miss_tracker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [0] kind, [32:1] address
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [2:0] l1_status, [5:3] l2_status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tlc_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_L1, S_L2, S_DONE} state_t;

	state_t      state_q;
	logic [3:0]  l1_off_q, l1_sets_q, l2_off_q, l2_sets_q, l2_ways_q;
	logic [2:0]  l1_ways_q;
	logic        kind_q;
	logic [31:0] addr_q;
	logic [2:0]  s1_q, s2_q;
	logic [5:0]  res_q;
	logic        out_v_q;
	logic [3:0]  l1_sb, l2_sb;
	logic [4:0]  l1_w, l2_w;
	logic        l1_start, l2_start, l1_inst, l2_inst;
	lvl_res_t    l1_res, l2_res;
	logic        l1_clr_done;
	logic [2:0]  reg_idx;

	assign l1_sb = (l1_sets_q > 4'(L1_SETS_LOG2)) ? 4'(L1_SETS_LOG2) : l1_sets_q;
	assign l2_sb = (l2_sets_q > 4'(L2_SETS_LOG2)) ? 4'(L2_SETS_LOG2) : l2_sets_q;
	assign l1_w  = (l1_ways_q == 3'd0) ? 5'd1 :
		(5'(l1_ways_q) > 5'(L1_WAYS_MAX)) ? 5'(L1_WAYS_MAX) : 5'(l1_ways_q);
	assign l2_w  = (l2_ways_q == 4'd0) ? 5'd1 :
		(5'(l2_ways_q) > 5'(L2_WAYS_MAX)) ? 5'(L2_WAYS_MAX) : 5'(l2_ways_q);

	// Readiness waits for both clearing passes; the second level's is longer.
	assign s_tready = (state_q == S_IDLE) && l1_clr_done;
	assign l1_start = s_tvalid && s_tready;
	assign l2_start = (state_q == S_L1) && !l1_res.hit;
	assign l1_inst  = !kind_q && !l1_res.hit && l2_res.done;
	assign l2_inst  = !kind_q && !l2_res.hit && l2_res.done;

	tlc_level #(.SETS_LOG2(L1_SETS_LOG2), .WAYS_MAX(L1_WAYS_MAX), .WAY_W(L1_WAY_W)) u_l1 (
		.clk, .arst_n, .start(l1_start), .do_install(l1_inst),
		.address(s_tdata[32:1]), .off_bits(l1_off_q), .set_bits(l1_sb),
		.ways(l1_w), .res(l1_res)
	);

	tlc_level #(.SETS_LOG2(L2_SETS_LOG2), .WAYS_MAX(L2_WAYS_MAX), .WAY_W(L2_WAY_W)) u_l2 (
		.clk, .arst_n, .start(l2_start), .do_install(l2_inst),
		.address(addr_q), .off_bits(l2_off_q), .set_bits(l2_sb),
		.ways(l2_w), .res(l2_res)
	);

	// Clearing tracker for the larger memory: one row per cycle after reset.
	logic [10:0] clr_cnt_q;
	assign l1_clr_done = clr_cnt_q[10];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (!clr_cnt_q[10])
			clr_cnt_q <= clr_cnt_q + 11'd1;
	end

	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_L1_OFF:  prdata = 32'(l1_off_q);
			REG_L1_SETS: prdata = 32'(l1_sets_q);
			REG_L1_WAYS: prdata = 32'(l1_ways_q);
			REG_L2_OFF:  prdata = 32'(l2_off_q);
			REG_L2_SETS: prdata = 32'(l2_sets_q);
			REG_L2_WAYS: prdata = 32'(l2_ways_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_off_q  <= 4'd3;
			l1_sets_q <= 4'd8;
			l1_ways_q <= 3'd4;
			l2_off_q  <= 4'd4;
			l2_sets_q <= 4'd10;
			l2_ways_q <= 4'd8;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_L1_OFF:  l1_off_q  <= pwdata[3:0];
				REG_L1_SETS: l1_sets_q <= pwdata[3:0];
				REG_L1_WAYS: l1_ways_q <= pwdata[2:0];
				REG_L2_OFF:  l2_off_q  <= pwdata[3:0];
				REG_L2_SETS: l2_sets_q <= pwdata[3:0];
				REG_L2_WAYS: l2_ways_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
			kind_q  <= 1'b0;
			addr_q  <= '0;
			s1_q    <= ST_NONE;
			s2_q    <= ST_NONE;
			res_q   <= '0;
		end else begin
			// The output register is refilled in the cycle its transfer completes.
			if (state_q == S_DONE && (!out_v_q || m_tready))
				out_v_q <= 1'b1;
			else if (m_tvalid && m_tready)
				out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (l1_start) begin
						kind_q  <= s_tdata[0];
						addr_q  <= s_tdata[32:1];
						state_q <= S_L1;
					end
				end
				S_L1: begin
					if (l1_res.hit) begin
						s1_q    <= kind_q ? ST_WHIT : ST_RHIT;
						s2_q    <= ST_NONE;
						state_q <= S_DONE;
					end else begin
						s1_q    <= kind_q ? ST_WMISS : ST_RMISS;
						state_q <= S_L2;
					end
				end
				S_L2: begin
					if (l2_res.hit)
						s2_q <= kind_q ? ST_WHIT : ST_RHIT;
					else
						s2_q <= kind_q ? ST_WMISS : ST_RMISS;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_v_q || m_tready) begin
						res_q   <= {s2_q, s1_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {2'b00, res_q};

`ifndef SYNTH
	a_l2_none_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[2:0] == ST_RHIT || m_tdata[2:0] == ST_WHIT) ==
			(m_tdata[5:3] == ST_NONE)))
		else $error("L2 status inconsistent with L1 outcome");
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second access accepted while one is in flight");
	a_l2_only_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		l2_start |-> !l1_res.hit)
		else $error("L2 accessed after an L1 hit");
`endif
endmodule

// File: rtl/core/tlc_level.sv
// One cache level: tag, valid and pointer memories with lookup and install.
module tlc_level #(
	parameter int SETS_LOG2 = 8,
	parameter int WAYS_MAX  = 4,
	parameter int WAY_W     = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    do_install,
	input  logic [31:0]             address,
	input  logic [3:0]              off_bits,
	input  logic [3:0]              set_bits,
	input  logic [4:0]              ways,
	output tlc_pkg::lvl_res_t       res
);
	import tlc_pkg::*;

	localparam int SETS    = 1 << SETS_LOG2;
	localparam int SET_W   = SETS_LOG2 > 0 ? SETS_LOG2 : 1;
	localparam int CLR_W   = SET_W + 1;

	// Memories: one row per set holds all ways.
	logic [WAYS_MAX-1:0][31:0] tag_mem [SETS];
	logic [WAYS_MAX-1:0]       val_mem [SETS];
	logic [WAY_W-1:0]          ptr_mem [SETS];

	logic [WAYS_MAX-1:0][31:0] tag_rd_q;
	logic [WAYS_MAX-1:0]       val_rd_q;
	logic [WAY_W-1:0]          ptr_rd_q;
	logic [SET_W-1:0]          set_s1;
	logic [31:0]               addr_s1;
	logic                      busy_s1;
	logic [CLR_W-1:0]          clr_q;
	logic                      clearing;

	logic [SET_W-1:0]          set_idx;
	logic [31:0]               set_mask;
	logic [4:0]                shamt;
	logic [WAYS_MAX-1:0]       way_hit;
	logic [WAYS_MAX-1:0]       way_inv;
	logic                      any_inv;
	logic [WAY_W-1:0]          first_inv;
	logic [WAY_W-1:0]          victim;
	logic [WAY_W-1:0]          nxt_ptr;
	logic [4:0]                vic_ext;

	assign clearing = !clr_q[CLR_W-1];
	assign set_mask = (32'd1 << set_bits) - 32'd1;
	assign set_idx  = SET_W'((address >> off_bits) & set_mask);
	assign shamt    = 5'(off_bits) + 5'(set_bits);

	always_comb begin
		way_hit   = '0;
		way_inv   = '0;
		first_inv = '0;
		any_inv   = 1'b0;
		for (int w = 0; w < WAYS_MAX; w++) begin
			if (5'(w) < ways) begin
				way_hit[w] = val_rd_q[w] && (((tag_rd_q[w] ^ addr_s1) >> shamt) == 32'd0);
				way_inv[w] = !val_rd_q[w];
			end
		end
		for (int w = WAYS_MAX - 1; w >= 0; w--) begin
			if (way_inv[w]) begin
				first_inv = WAY_W'(w);
				any_inv   = 1'b1;
			end
		end
		victim = (5'(ptr_rd_q) < ways) ? ptr_rd_q : '0;
		vic_ext = 5'(victim) + 5'd1;
		nxt_ptr = (vic_ext >= ways) ? '0 : WAY_W'(vic_ext);
	end

	assign res.hit  = |way_hit;
	assign res.done = busy_s1;

	// Clearing pass after reset walks every set once; the busy flag registers each start outside it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			busy_s1 <= 1'b0;
		end else begin
			if (clearing)
				clr_q <= clr_q + CLR_W'(1);
			busy_s1 <= start && !clearing;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing) begin
			val_mem[clr_q[SET_W-1:0]] <= '0;
			ptr_mem[clr_q[SET_W-1:0]] <= '0;
		end else if (do_install) begin
			if (any_inv) begin
				tag_mem[set_s1][first_inv] <= addr_s1;
				val_mem[set_s1][first_inv] <= 1'b1;
			end else begin
				tag_mem[set_s1][victim] <= addr_s1;
				ptr_mem[set_s1]         <= nxt_ptr;
			end
		end
		if (start) begin
			tag_rd_q <= tag_mem[set_idx];
			val_rd_q <= val_mem[set_idx];
			ptr_rd_q <= ptr_mem[set_idx];
			set_s1   <= set_idx;
			addr_s1  <= address;
		end
	end

`ifndef SYNTH
	a_inst_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		do_install |-> !clearing)
		else $error("install during clearing pass");
	a_hit_no_install: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_s1 && res.hit) |-> !do_install)
		else $error("install on a hit");
	a_no_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |=> !busy_s1)
		else $error("access during clearing pass");
`endif
endmodule
